### design/utf8dec_pkg.sv
// ----------------------------------------------------------------------------
// utf8dec_pkg
// Shared constants and helpers for the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8dec_pkg;

  localparam int unsigned CpW      = 21;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CntW     = 3;

  localparam logic [CpW-1:0] ReplCp = 21'h00FFFD;
  localparam logic [CpW-1:0] MaxCp  = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi = 21'h00DFFF;

  // Smallest code point that a sequence with this many continuation bytes may carry
  function automatic logic [CpW-1:0] min_for_len(input logic [1:0] extra);
    logic [CpW-1:0] lo;
    case (extra)
      2'd1:    lo = 21'h000080;
      2'd2:    lo = 21'h000800;
      2'd3:    lo = 21'h010000;
      default: lo = '0;
    endcase
    return lo;
  endfunction

endpackage

`default_nettype wire

### design/utf8_to_codepoint_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_unit
// Streaming UTF-8 decoder with U+FFFD replacement, one byte per transfer.
// ----------------------------------------------------------------------------
// A byte is decoded in the cycle it is taken; the results it causes are held
// in a burst register (count and final code point) and handed out one per
// cycle, while the output side is not stalled, through a registered output
// stage. A byte that causes at most one result is taken every cycle as long
// as the output side keeps taking transfers; a byte that causes n results (up
// to four) holds the input while the burst register drains. All results of a
// burst except the last are U+FFFD, and out_tlast marks the last one.
`default_nettype none

module utf8_to_codepoint_decoder_unit
  import utf8dec_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output      logic                in_tready,
  input  wire logic [InDataW-1:0]  in_tdata,   // [7:0] data_byte
  input  wire logic                in_tlast,   // string_end
  output      logic                out_tvalid,
  input  wire logic                out_tready,
  output      logic [OutDataW-1:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output      logic                out_tlast   // run_last
);

  // Decoder state
  logic [1:0]     needed_r, needed_nxt;
  logic [1:0]     received_r, received_nxt;
  logic [CpW-1:0] partial_r, partial_nxt;

  // Burst register
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CpW-1:0]  cp_r, cp_nxt;

  // Output stage
  logic           out_valid_r;
  logic [CpW-1:0] out_cp_r;
  logic           out_last_r;

  logic in_accept;
  logic out_load;

  logic [7:0] b;
  logic       is_cont;

  // Lead byte decode
  logic [CntW-1:0] lead_cnt;
  logic [CpW-1:0]  lead_cp;
  logic            lead_pend;
  logic [1:0]      lead_extra;
  logic [CpW-1:0]  lead_bits;

  logic [1:0]      rc_inc;
  logic [CpW-1:0]  part_ext;
  logic            part_bad;
  logic [CntW-1:0] desc_cnt;
  logic [CpW-1:0]  desc_cp;

  assign b       = in_tdata;
  assign is_cont = (b[7:6] == 2'b10);

  assign out_load  = (cnt_r != '0) && (!out_valid_r || out_tready);
  assign in_tready = (cnt_r == '0) || ((cnt_r == CntW'(1)) && out_load);
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    lead_cnt   = CntW'(1);
    lead_cp    = ReplCp;
    lead_pend  = 1'b0;
    lead_extra = 2'd0;
    lead_bits  = '0;
    if (!b[7]) begin
      lead_cp = CpW'(b);
    end else if (b[7:5] == 3'b110) begin
      lead_extra = 2'd1;
      lead_bits  = CpW'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      lead_extra = 2'd2;
      lead_bits  = CpW'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      lead_extra = 2'd3;
      lead_bits  = CpW'(b[2:0]);
    end
    // A valid lead waits for continuations unless the string ends here
    if (lead_extra != 2'd0 && !in_tlast) begin
      lead_cnt  = '0;
      lead_pend = 1'b1;
    end
  end

  always_comb begin
    rc_inc   = received_r + 2'd1;
    part_ext = {partial_r[CpW-7:0], b[5:0]};
    part_bad = (part_ext < min_for_len(needed_r)) || (part_ext > MaxCp) ||
               ((part_ext >= SurrLo) && (part_ext <= SurrHi));

    needed_nxt   = needed_r;
    received_nxt = received_r;
    partial_nxt  = partial_r;
    desc_cnt     = '0;
    desc_cp      = ReplCp;

    if (needed_r == 2'd0) begin
      desc_cnt = lead_cnt;
      desc_cp  = lead_cp;
      if (lead_pend) begin
        needed_nxt   = lead_extra;
        received_nxt = 2'd0;
        partial_nxt  = lead_bits;
      end
    end else if (is_cont) begin
      if (rc_inc == needed_r) begin
        if (part_bad) begin
          desc_cnt = {1'b0, rc_inc} + CntW'(1);
        end else begin
          desc_cnt = CntW'(1);
          desc_cp  = part_ext;
        end
        needed_nxt   = 2'd0;
        received_nxt = 2'd0;
        partial_nxt  = '0;
      end else if (in_tlast) begin
        desc_cnt     = {1'b0, rc_inc} + CntW'(1);
        needed_nxt   = 2'd0;
        received_nxt = 2'd0;
        partial_nxt  = '0;
      end else begin
        received_nxt = rc_inc;
        partial_nxt  = part_ext;
      end
    end else begin
      // Broken sequence: flush lead and continuations, then decode afresh
      desc_cnt = {1'b0, received_r} + CntW'(1) + lead_cnt;
      if (lead_cnt != '0) begin
        desc_cp = lead_cp;
      end
      if (lead_pend) begin
        needed_nxt   = lead_extra;
        received_nxt = 2'd0;
        partial_nxt  = lead_bits;
      end else begin
        needed_nxt   = 2'd0;
        received_nxt = 2'd0;
        partial_nxt  = '0;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    cp_nxt  = cp_r;
    if (in_accept) begin
      cnt_nxt = desc_cnt;
      cp_nxt  = desc_cp;
    end else if (out_load) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needed_r    <= 2'd0;
      received_r  <= 2'd0;
      partial_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        needed_r   <= needed_nxt;
        received_r <= received_nxt;
        partial_r  <= partial_nxt;
      end
      cnt_r <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_r <= cp_nxt;
    if (out_load) begin
      out_cp_r   <= (cnt_r == CntW'(1)) ? cp_r : ReplCp;
      out_last_r <= (cnt_r == CntW'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutDataW - CpW)'(0), out_cp_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### design/utf8dec_checker.sv
// ----------------------------------------------------------------------------
// utf8dec_checker
// Port-level checks for the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8dec_checker
  import utf8dec_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_tready,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OutDataW-1:0] out_tdata,
  input wire logic                out_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Results before the last of a burst are always replacements
  a_early_repl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[CpW-1:0] == ReplCp)
    else $error("non-final result is not U+FFFD");

  // Never emit a surrogate, a value above the Unicode range, or stray pad bits
  a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[CpW-1:0] <= MaxCp) &&
                   !((out_tdata[CpW-1:0] >= SurrLo) && (out_tdata[CpW-1:0] <= SurrHi)) &&
                   (out_tdata[OutDataW-1:CpW] == '0))
    else $error("result outside the scalar value range");

  // Come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // Take input straight after reset
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready straight after reset");

endmodule

bind utf8_to_codepoint_decoder_unit utf8dec_checker u_utf8dec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to code point decoder: byte strings go in
// through the input stream, and every code point that comes out is compared
// with a behavioural decoder that runs alongside, including tlast per burst.
// ----------------------------------------------------------------------------
module tb;
  import utf8dec_pkg::*;

  typedef struct packed {
    logic [InDataW-1:0] data;
    logic               str_end;
  } utf8_byte_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           lst;
  } cp_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;

  utf8_to_codepoint_decoder_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  utf8_byte_t tx_bytes[$];
  utf8_byte_t str_bytes[$];
  utf8_byte_t next_byte;
  cp_result_t pending_cps[$];
  cp_result_t want;

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int strings_sent = 0;
  int cps_checked = 0;
  int repl_count = 0;

  // Decoder state mirrored from the block
  logic [1:0]     need_cont = '0;
  logic [1:0]     got_cont = '0;
  logic [CpW-1:0] acc_cp = '0;
  logic [CpW-1:0] burst_cps[0:3];
  int             burst_n;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #3000000;
    $display("utf8_to_codepoint_decoder_unit test failed");
    $finish;
  end

  task automatic put_cp(input logic [CpW-1:0] cp);
    burst_cps[burst_n] = cp;
    burst_n++;
  endtask

  task automatic drop_pending();
    need_cont = '0;
    got_cont = '0;
    acc_cp = '0;
  endtask

  // Replace the lead byte and each continuation taken so far
  task automatic flush_bad();
    int k;
    put_cp(ReplCp);
    for (k = 0; k < got_cont; k++) put_cp(ReplCp);
    drop_pending();
  endtask

  task automatic start_char(input logic [7:0] b, input logic at_end);
    logic [1:0]     extra;
    logic [CpW-1:0] bits;
    extra = '0;
    bits = '0;
    casez (b)
      8'b0???????: put_cp(CpW'(b));
      8'b110?????: begin
        extra = 2'd1;
        bits = CpW'(b[4:0]);
      end
      8'b1110????: begin
        extra = 2'd2;
        bits = CpW'(b[3:0]);
      end
      8'b11110???: begin
        extra = 2'd3;
        bits = CpW'(b[2:0]);
      end
      default: put_cp(ReplCp);
    endcase
    if (extra != 0) begin
      if (at_end) begin
        put_cp(ReplCp);
      end else begin
        need_cont = extra;
        got_cont = '0;
        acc_cp = bits;
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic at_end);
    logic [CpW-1:0] floor_cp;
    int             i;
    cp_result_t     res;
    burst_n = 0;
    if (need_cont == 0) begin
      start_char(b, at_end);
    end else if (b[7:6] == 2'b10) begin
      acc_cp = {acc_cp[CpW-7:0], b[5:0]};
      got_cont++;
      if (got_cont >= need_cont) begin
        case (need_cont)
          2'd1:    floor_cp = 21'h000080;
          2'd2:    floor_cp = 21'h000800;
          default: floor_cp = 21'h010000;
        endcase
        if (acc_cp < floor_cp || acc_cp > MaxCp || (acc_cp >= SurrLo && acc_cp <= SurrHi)) begin
          flush_bad();
        end else begin
          put_cp(acc_cp);
          drop_pending();
        end
      end else if (at_end) begin
        flush_bad();
      end
    end else begin
      // broken sequence: replace what was gathered, then take the byte as a new lead
      flush_bad();
      start_char(b, at_end);
    end
    for (i = 0; i < burst_n; i++) begin
      res.cp = burst_cps[i];
      res.lst = (i == burst_n - 1);
      pending_cps.insert(pending_cps.size(), res);
    end
  endtask

  // Driver: advance to the next byte once the current transfer is done
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast);
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
          next_byte = tx_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= next_byte.data;
          in_tlast <= next_byte.str_end;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expected code point
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_cps.size() == 0) begin
          $error("code_point: none expected, got %h", out_tdata[CpW-1:0]);
          fail_count++;
        end else begin
          want = pending_cps.pop_front();
          cps_checked++;
          if (want.cp == ReplCp) repl_count++;
          if (out_tdata[CpW-1:0] !== want.cp) begin
            $error("code_point: expected %h, got %h", want.cp, out_tdata[CpW-1:0]);
            fail_count++;
          end
          if (out_tlast !== want.lst) begin
            $error("run_last: expected %b, got %b", want.lst, out_tlast);
            fail_count++;
          end
          if (out_tdata[OutDataW-1:CpW] !== '0) begin
            $error("padding: expected 0, got %h", out_tdata[OutDataW-1:CpW]);
            fail_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic stage(input logic [7:0] b, input logic e);
    utf8_byte_t item;
    item.data = b;
    item.str_end = e;
    str_bytes.insert(str_bytes.size(), item);
  endtask

  // Encode cp in len bytes without range checks, keep only the first keep bytes
  task automatic stage_seq(input logic [CpW-1:0] cp, input int len, input int keep);
    logic [7:0] seq[0:3];
    int         i;
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (i = 0; i < keep; i++) stage(seq[i], 1'b0);
  endtask

  task automatic send_staged();
    tx_bytes = {tx_bytes, str_bytes};
    bytes_queued += str_bytes.size();
    str_bytes.delete();
    strings_sent++;
  endtask

  task automatic add_string();
    int             sel;
    int             len;
    logic [CpW-1:0] cp;
    repeat ($urandom_range(1, 6)) begin
      sel = $urandom_range(99);
      len = $urandom_range(1, 4);
      if (sel < 55) begin
        case (len)
          1: cp = CpW'($urandom_range(0, 'h7F));
          2: cp = CpW'($urandom_range('h80, 'h7FF));
          3: begin
            cp = CpW'($urandom_range('h800, 'hFFFF));
            if (cp >= SurrLo && cp <= SurrHi) cp ^= 21'h002000;
          end
          default: cp = CpW'($urandom_range('h10000, 'h10FFFF));
        endcase
        stage_seq(cp, len, len);
      end else if (sel < 67) begin
        case ($urandom_range(2))
          0: begin
            len = $urandom_range(2, 4);
            cp = CpW'($urandom_range(0, len == 2 ? 'h7F : len == 3 ? 'h7FF : 'hFFFF));
          end
          1: begin
            len = 3;
            cp = CpW'($urandom_range('hD800, 'hDFFF));
          end
          default: begin
            len = 4;
            cp = CpW'($urandom_range('h110000, 'h1FFFFF));
          end
        endcase
        stage_seq(cp, len, len);
      end else if (sel < 80) begin
        len = $urandom_range(2, 4);
        cp = CpW'($urandom_range(0, 'h1FFFFF));
        stage_seq(cp, len, $urandom_range(1, len - 1));
      end else if (sel < 92) begin
        stage(8'($urandom_range(255)), 1'b0);
      end else if (sel < 96) begin
        stage(8'($urandom_range('hF8, 'hFF)), 1'b0);
      end else begin
        stage(8'($urandom_range('h80, 'hBF)), 1'b0);
      end
    end
    // leave some strings open so the next one runs into a pending sequence
    if ($urandom_range(9) != 0) str_bytes[str_bytes.size() - 1].str_end = 1'b1;
    send_staged();
  endtask

  // Hold the sender until every queued byte is taken and every result is in
  task automatic drain();
    do @(negedge clk);
    while (tx_bytes.size() > 0 || in_tvalid || pending_cps.size() > 0);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n_bytes);
    int target;
    @(negedge clk);
    idle_pct = idle;
    stall_pct = stall;
    target = bytes_queued + n_bytes;
    while (bytes_queued < target) add_string();
    drain();
  endtask

  initial begin
    wait (rst_n === 1'b1);
    @(negedge clk);
    // extremes and invalid leads
    stage(8'h00, 1'b0);
    stage(8'h80, 1'b0);
    stage(8'hFF, 1'b1);
    // lead byte as last byte of a string
    stage(8'hC3, 1'b1);
    // two-byte form
    stage(8'hC3, 1'b0);
    stage(8'hA9, 1'b0);
    // non-continuation breaks a sequence after one continuation
    stage(8'hE2, 1'b0);
    stage(8'h82, 1'b0);
    stage(8'h41, 1'b0);
    // string ends on a continuation with the sequence still open
    stage(8'hF0, 1'b0);
    stage(8'h9F, 1'b0);
    stage(8'h98, 1'b1);
    // overlong
    stage(8'hC0, 1'b0);
    stage(8'h80, 1'b0);
    // surrogate
    stage(8'hED, 1'b0);
    stage(8'hA0, 1'b0);
    stage(8'h80, 1'b0);
    // above the code space: four replacements from one byte
    stage(8'hF4, 1'b0);
    stage(8'h90, 1'b0);
    stage(8'h80, 1'b0);
    stage(8'h80, 1'b0);
    // highest valid code point
    stage(8'hF4, 1'b0);
    stage(8'h8F, 1'b0);
    stage(8'hBF, 1'b0);
    stage(8'hBF, 1'b1);
    send_staged();
    drain();

    run_phase(0, 0, 108);
    run_phase(53, 0, 108);
    run_phase(0, 53, 108);
    run_phase(10, 10, 108);

    // let any stray result surface before the verdict
    repeat (20) @(negedge clk);
    $display("Covered %0d bytes in %0d strings, %0d code points checked, %0d of them U+FFFD.",
             bytes_taken, strings_sent, cps_checked, repl_count);
    if (fail_count == 0) begin
      $display("utf8_to_codepoint_decoder_unit test passed");
    end else begin
      $display("utf8_to_codepoint_decoder_unit test failed");
    end
    $finish;
  end

endmodule
